>>> rtl/okle_pkg.sv
// Shared types and constants for the ordered key list engine.
package okle_pkg;

    // Default number of key slots
    localparam int CAPACITY_DEFAULT = 16;

    // Request opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // Request transaction payload
    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] key;
    } okle_in_t;

    // Result transaction payload
    typedef struct packed {
        logic       found;
        logic [3:0] position;
        logic       full_refused;
        logic [4:0] entry_count;
    } okle_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic compare;
        logic locate;
        logic execute;
    } okle_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy;
    } okle_status_t;

endpackage

>>> rtl/okle_ctrl.sv
// Request sequencer: capture, compare, locate first match, execute.
module okle_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   out_ready,
    input  okle_pkg::okle_status_t status,
    output okle_pkg::okle_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_COMPARE = 2'd1;
    localparam logic [1:0] ST_LOCATE  = 2'd2;
    localparam logic [1:0] ST_EXECUTE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = ST_LOCATE;
            end
            ST_LOCATE:
            begin
                cmd.locate = 1'b1;
                state_next = ST_EXECUTE;
            end
            ST_EXECUTE:
            begin
                // wait for the result register to free up
                if (!status.out_busy || out_ready)
                begin
                    cmd.execute = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/okle_datapath.sv
// Slot array, parallel compare, first-match locate, shift and result register.
module okle_datapath #(
    parameter int CAPACITY = okle_pkg::CAPACITY_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  okle_pkg::okle_cmd_t    cmd,
    output okle_pkg::okle_status_t status,
    input  okle_pkg::okle_in_t     in_data,
    input  logic                   out_ready,
    output logic                   out_valid,
    output okle_pkg::okle_out_t    out_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [1:0]          op_reg;
    logic [31:0]         key_reg;
    logic [31:0]         slot_reg [CAPACITY];
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CAPACITY-1:0] match_reg;
    logic [CAPACITY-1:0] first_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    okle_pkg::okle_out_t out_data_reg;
    okle_pkg::okle_out_t out_data_next;

    logic [CAPACITY-1:0] match_vec;
    logic [CAPACITY-1:0] shift_mask;
    logic [IDX_W-1:0]    first_idx;
    logic                hit;
    logic                do_insert;
    logic                do_remove;
    logic                refused;
    logic [31:0]         idx_wide;
    logic [31:0]         cnt_wide;

    // Compare every live slot against the key
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
            match_vec[i] = (slot_reg[i] == key_reg) && (CNT_W'(i) < count_reg);
    end

    // Encode the one-hot first match and build the shift mask
    always_comb
    begin
        first_idx = '0;
        for (int i = 0; i < CAPACITY; i++)
            if (first_reg[i])
                first_idx = first_idx | IDX_W'(i);
        hit        = |first_reg;
        shift_mask = ~(first_reg - CAPACITY'(1));
    end

    // Result and next count
    always_comb
    begin
        do_insert  = (op_reg == okle_pkg::OP_INSERT) && (count_reg < CAP_CNT);
        refused    = (op_reg == okle_pkg::OP_INSERT) && !(count_reg < CAP_CNT);
        do_remove  = (op_reg == okle_pkg::OP_REMOVE) && hit;
        count_next = count_reg;
        if (do_insert)
            count_next = count_reg + CNT_W'(1);
        else if (do_remove)
            count_next = count_reg - CNT_W'(1);
        idx_wide = 32'(first_idx);
        cnt_wide = 32'(count_next);
        out_data_next.found        = hit && ((op_reg == okle_pkg::OP_SEARCH) ||
                                             (op_reg == okle_pkg::OP_REMOVE));
        out_data_next.position     = out_data_next.found ? idx_wide[3:0] : 4'd0;
        out_data_next.full_refused = refused;
        out_data_next.entry_count  = cnt_wide[4:0];
    end

    // Output handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.execute)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Request capture and match registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_data.opcode;
            key_reg <= in_data.key;
        end
        if (cmd.compare)
            match_reg <= match_vec;
        if (cmd.locate)
            first_reg <= match_reg & (~match_reg + CAPACITY'(1));
        if (cmd.execute)
            out_data_reg <= out_data_next;
    end

    // Slot array: shift back on insert, close the gap on remove
    always_ff @(posedge clk)
    begin
        if (cmd.execute && do_insert)
        begin
            for (int i = CAPACITY - 1; i > 0; i--)
                slot_reg[i] <= slot_reg[i-1];
            slot_reg[0] <= key_reg;
        end
        else if (cmd.execute && do_remove)
        begin
            for (int i = 0; i < CAPACITY - 1; i++)
                if (shift_mask[i])
                    slot_reg[i] <= slot_reg[i+1];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.execute)
                count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.out_busy = out_valid_reg;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule

>>> rtl/ordered_key_list_engine_unit.sv
// Top level of the ordered key list engine: controller plus datapath.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | in_data  (opcode, key)
//  out     | out_valid/ out_ready | out_data (found, position, full_refused,
//          |                      |           entry_count)
//
// Each request passes from acceptance to result through capture, compare of
// all slots in parallel, first-match isolation, then execute (shift + result).
// One request is in flight at a time; the next is accepted once execute ends.
// A result waits in the output register; execute stalls only if that register
// is still occupied and out_ready is low.
// Reset (rst_n low) empties the list and drops any pending result.
module ordered_key_list_engine_unit #(
    parameter int CAPACITY = okle_pkg::CAPACITY_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  okle_pkg::okle_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output okle_pkg::okle_out_t out_data
);

    okle_pkg::okle_cmd_t    cmd;
    okle_pkg::okle_status_t status;

    okle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    okle_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the ordered key list engine: random and directed requests, scoreboard.
module tb;

    localparam int SLOTS = okle_pkg::CAPACITY_DEFAULT;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_REQS = 550;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [31:0] KEY_MIN = 32'h8000_0000;
    localparam logic [31:0] KEY_MAX = 32'h7fff_ffff;

    // Request waiting in the driver queue
    typedef struct {
        okle_pkg::okle_in_t req;
        bit                 hold;   // wait until every outstanding result is back
        int                 phase;  // selects the idle mix
    } pending_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    okle_pkg::okle_in_t  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    okle_pkg::okle_out_t out_data;

    pending_t            pending_reqs[$];
    okle_pkg::okle_out_t expected_results[$];
    logic [31:0]         key_pool[8];
    logic [31:0]         list_keys[SLOTS];
    int                  list_count = 0;
    int                  cur_phase = 0;
    int                  errors = 0;
    int                  idle_cycles = 0;

    ordered_key_list_engine_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #6 clk = ~clk;

    // Shadow list: apply one request and return the result it should produce
    function automatic okle_pkg::okle_out_t list_apply(okle_pkg::okle_in_t req);
        okle_pkg::okle_out_t res;
        int                  hit;
        res = '0;
        hit = -1;
        for (int i = 0; i < list_count; i++)
            if (hit < 0 && list_keys[i] == req.key)
                hit = i;
        case (req.opcode)
            okle_pkg::OP_INSERT:
                if (list_count >= SLOTS)
                    res.full_refused = 1'b1;
                else
                begin
                    for (int i = list_count; i > 0; i--)
                        list_keys[i] = list_keys[i - 1];
                    list_keys[0] = req.key;
                    list_count++;
                end
            okle_pkg::OP_SEARCH:
                if (hit >= 0)
                begin
                    res.found = 1'b1;
                    res.position = 4'(hit);
                end
            okle_pkg::OP_REMOVE:
                if (hit >= 0)
                begin
                    res.found = 1'b1;
                    res.position = 4'(hit);
                    for (int i = hit; i + 1 < list_count; i++)
                        list_keys[i] = list_keys[i + 1];
                    list_count--;
                end
            default: ;
        endcase
        res.entry_count = 5'(list_count);
        return res;
    endfunction

    task automatic queue_request(logic [1:0] op, logic [31:0] key, bit hold, int phase);
        pending_t p;
        p.req.opcode = op;
        p.req.key = key;
        p.hold = hold;
        p.phase = phase;
        pending_reqs.push_back(p);
    endtask

    // Mostly keys from a small pool so searches and removes hit
    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return key_pool[$urandom_range(0, 7)];
        if (r == 6)
            case ($urandom_range(0, 3))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return 32'h0;
                default: return 32'hffff_ffff;
            endcase
        return $urandom;
    endfunction

    function automatic int send_idle_pct(int phase);
        return (phase == 0) ? 33 : (phase == 1) ? 67 : 0;
    endfunction

    function automatic int recv_idle_pct(int phase);
        return (phase == 0) ? 67 : (phase == 1) ? 33 : 0;
    endfunction

    task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("[%0t] %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Driver: record accepted transactions, present the next one
    always @(posedge clk)
    begin
        pending_t head;
        bit       launch;
        launch = 1'b0;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(list_apply(in_data));
            if (!in_valid || in_ready)
            begin
                if (pending_reqs.size() != 0)
                begin
                    head = pending_reqs[0];
                    if (!(head.hold && expected_results.size() != 0)
                        && $urandom_range(0, 99) >= send_idle_pct(head.phase))
                    begin
                        launch = 1'b1;
                        void'(pending_reqs.pop_front());
                    end
                end
                in_valid <= launch;
                if (launch)
                begin
                    in_data <= head.req;
                    cur_phase <= head.phase;
                end
            end
        end
    end

    // Result side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct(cur_phase));
    end

    // Monitor: compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        okle_pkg::okle_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("[%0t] unexpected result, actual %p", $time, out_data);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                report_field("found", 32'(want.found), 32'(out_data.found));
                report_field("position", 32'(want.position), 32'(out_data.position));
                report_field("full_refused", 32'(want.full_refused),
                             32'(out_data.full_refused));
                report_field("entry_count", 32'(want.entry_count),
                             32'(out_data.entry_count));
            end
        end
    end

    // Watchdog on cycles without any accepted transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] no progress for %0d cycles", $time, idle_cycles);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int made;
        int kind;
        int len;
        int phase;
        int r;
        bit hold;
        logic [1:0] op;

        for (int i = 0; i < 8; i++)
            key_pool[i] = (i < 3) ? 32'(i * 5 + 1) : $urandom;

        // Directed: empty list, extremes, duplicates, misses, unused opcode, full list
        queue_request(okle_pkg::OP_SEARCH, 32'h0, 1'b0, 0);
        queue_request(okle_pkg::OP_REMOVE, 32'h0, 1'b0, 0);
        queue_request(OP_UNUSED, 32'hffff_ffff, 1'b0, 0);
        queue_request(okle_pkg::OP_INSERT, KEY_MIN, 1'b0, 0);
        queue_request(okle_pkg::OP_INSERT, KEY_MAX, 1'b0, 0);
        queue_request(okle_pkg::OP_INSERT, 32'h0, 1'b0, 0);
        queue_request(okle_pkg::OP_INSERT, 32'hffff_ffff, 1'b0, 0);
        queue_request(okle_pkg::OP_INSERT, 32'd7, 1'b0, 0);
        queue_request(okle_pkg::OP_INSERT, 32'd7, 1'b0, 0);
        queue_request(okle_pkg::OP_SEARCH, KEY_MIN, 1'b0, 0);
        queue_request(okle_pkg::OP_SEARCH, 32'd7, 1'b0, 0);
        queue_request(okle_pkg::OP_REMOVE, 32'd7, 1'b0, 0);
        queue_request(okle_pkg::OP_SEARCH, 32'd7, 1'b0, 0);
        queue_request(okle_pkg::OP_REMOVE, KEY_MIN, 1'b0, 0);
        queue_request(okle_pkg::OP_SEARCH, 32'd12345, 1'b0, 0);
        for (int i = 0; i < SLOTS - 4; i++)
            queue_request(okle_pkg::OP_INSERT, 32'(100 + i), 1'b0, 0);
        queue_request(okle_pkg::OP_INSERT, 32'd55, 1'b0, 0);
        queue_request(okle_pkg::OP_SEARCH, KEY_MAX, 1'b0, 0);
        queue_request(OP_UNUSED, KEY_MAX, 1'b0, 0);
        queue_request(okle_pkg::OP_REMOVE, KEY_MAX, 1'b0, 0);

        // Random bursts: fill runs, drain runs and mixed traffic
        made = 0;
        while (made < RANDOM_REQS)
        begin
            kind = $urandom_range(0, 9);
            len = (kind < 2) ? $urandom_range(10, 20) :
                  (kind == 2) ? $urandom_range(8, 18) : $urandom_range(5, 30);
            for (int j = 0; j < len && made < RANDOM_REQS; j++)
            begin
                phase = made * 3 / RANDOM_REQS;
                hold = (made == 0) || ((made * 3) % RANDOM_REQS < 3)
                       || ($urandom_range(0, 99) < 3);
                if (kind < 2)
                    op = ($urandom_range(0, 9) < 9) ? okle_pkg::OP_INSERT : okle_pkg::OP_SEARCH;
                else if (kind == 2)
                    op = ($urandom_range(0, 9) < 9) ? okle_pkg::OP_REMOVE : okle_pkg::OP_SEARCH;
                else
                begin
                    r = $urandom_range(0, 99);
                    op = (r < 40) ? okle_pkg::OP_INSERT : (r < 70) ? okle_pkg::OP_SEARCH :
                         (r < 95) ? okle_pkg::OP_REMOVE : OP_UNUSED;
                end
                queue_request(op, pick_key(), hold, phase);
                made++;
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every request to go out and every result to come back
        while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
rtl/okle_pkg.sv
rtl/okle_ctrl.sv
rtl/okle_datapath.sv
rtl/ordered_key_list_engine_unit.sv
bench/tb.sv
